// ----- design/fwwa_pkg.sv -----
package fwwa_pkg;

  // Width of the running byte address.
  localparam int ADDR_BITS = 24;
  // Width of the address field on the ports.
  localparam int PORT_ADDR_W = 24;
  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int CHUNK_LOG_W = 4;
  localparam int CHUNK_OFS_W = 12;
  localparam int NUM_SLOTS = 5;
  localparam int SLOT_W = 3;

  localparam logic [CHUNK_LOG_W-1:0] CHUNK_LOG_MIN = 4'd2;
  localparam logic [CHUNK_LOG_W-1:0] CHUNK_LOG_MAX = 4'd12;
  localparam logic [CHUNK_LOG_W-1:0] CHUNK_LOG_RST = 4'd6;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WORD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_ERASE = 1'b1;

  localparam logic CFG_CHUNK_SIZE_LOG2   = 1'b0;
  localparam logic CFG_ERASE_ADDR_HALVED = 1'b1;

  localparam logic [1:0] LANE_TOP = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [PORT_ADDR_W-1:0] out_address;
    logic [WORD_W-1:0]      word_data;
  } result_t;

endpackage

// ----- design/flash_write_word_aligner.sv -----
// A taken beat waits in the input register; its results move on to the
// output register driving out_. One input beat per cycle while each beat
// causes at most one result and out_tready is high; a beat with n results
// (n at most five) holds the input while they leave the single output
// register one per cycle as out_tready allows; no-result beats never wait.
// Reset (rst_n low, synchronous) empties both stages and all control state.
module flash_write_word_aligner import fwwa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [CHUNK_LOG_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // [23:0] address, [31:24] data_byte
  input  logic [1:0]             in_tuser,   // [0] opcode, [1] first
  input  logic                   in_tlast,   // last_in
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [55:0]            out_tdata,  // [23:0] out_address, [55:24] word_data
  output logic [KIND_W-1:0]      out_tuser,  // [1:0] kind
  output logic                   out_tlast   // last_out
);

  // Configuration registers.
  logic [CHUNK_LOG_W-1:0] chunk_log_r;
  logic                   erase_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_log_r  <= CHUNK_LOG_RST;
      erase_half_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CHUNK_SIZE_LOG2:   chunk_log_r  <= cfg_wdata;
        CFG_ERASE_ADDR_HALVED: erase_half_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register: one beat waits here until all of its results have
  // been moved into the output register.
  logic                   a_valid_r;
  logic                   a_op_r;
  logic                   a_first_r;
  logic                   a_last_r;
  logic [PORT_ADDR_W-1:0] a_addr_r;
  logic [BYTE_W-1:0]      a_byte_r;

  // Aligner state; it only advances when the held beat is retired.
  logic [WORD_W-1:0]    word_buf_r;
  logic [ADDR_BITS-1:0] next_addr_r;
  logic                 word_pend_r;
  logic                 chunk_open_r;
  logic                 run_open_r;

  // Index of the next result slot of the held beat to emit.
  logic [SLOT_W-1:0] slot_r;

  // Output register.
  logic    out_valid_r;
  result_t out_res_r;
  logic    out_last_r;

  // Result slots in emission order: flushed word, flushing commit, clear,
  // word or erase, closing commit.
  result_t           slot_res [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_v;

  logic [WORD_W-1:0]    word_buf_nxt;
  logic [ADDR_BITS-1:0] next_addr_nxt;
  logic                 word_pend_nxt;
  logic                 chunk_open_nxt;
  logic                 run_open_nxt;

  logic                   flush;
  logic [WORD_W-1:0]      wb_flushed;
  logic                   pend_flushed;
  logic                   chunk_flushed;
  logic [ADDR_BITS-1:0]   here;
  logic [ADDR_BITS-1:0]   here_inc;
  logic [1:0]             lane;
  logic [WORD_W-1:0]      wb_filled;
  logic                   emit_word;
  logic                   emit_commit;
  logic [CHUNK_LOG_W-1:0] chunk_log;
  logic [CHUNK_OFS_W-1:0] chunk_mask;
  logic [PORT_ADDR_W-1:0] erase_addr;
  logic [PORT_ADDR_W-1:0] flush_addr;

  always_comb begin
    // Chunk size is clamped to the supported range.
    chunk_log = chunk_log_r;
    if (chunk_log_r < CHUNK_LOG_MIN) begin
      chunk_log = CHUNK_LOG_MIN;
    end
    if (chunk_log_r > CHUNK_LOG_MAX) begin
      chunk_log = CHUNK_LOG_MAX;
    end
    chunk_mask = ~({CHUNK_OFS_W{1'b1}} << chunk_log);

    flush_addr = PORT_ADDR_W'({next_addr_r[ADDR_BITS-1:2], 2'b00});
    erase_addr = erase_half_r ? (a_addr_r >> 1) : a_addr_r;

    // A new first byte or an erase inside an open run flushes the run.
    flush         = run_open_r && ((a_op_r == OP_ERASE) || a_first_r);
    wb_flushed    = flush ? {WORD_W{1'b1}} : word_buf_r;
    pend_flushed  = flush ? 1'b0 : word_pend_r;
    chunk_flushed = flush ? 1'b0 : chunk_open_r;

    here      = a_first_r ? ADDR_BITS'(a_addr_r) : next_addr_r;
    here_inc  = here + ADDR_BITS'(1);
    lane      = here[1:0];
    wb_filled = wb_flushed;
    wb_filled[lane*BYTE_W +: BYTE_W] = a_byte_r;

    emit_word   = (lane == LANE_TOP) || a_last_r;
    emit_commit = ((here_inc[CHUNK_OFS_W-1:0] & chunk_mask) == '0) || a_last_r;

    slot_res[0] = '{kind: KIND_WORD, out_address: flush_addr, word_data: word_buf_r};
    slot_res[1] = '{kind: KIND_COMMIT, out_address: '0, word_data: '0};
    slot_res[2] = '{kind: KIND_CLEAR, out_address: '0, word_data: '0};
    slot_res[4] = '{kind: KIND_COMMIT, out_address: '0, word_data: '0};
    slot_v[0]   = flush && word_pend_r;
    slot_v[1]   = flush && chunk_open_r;

    if (a_op_r == OP_ERASE) begin
      slot_res[3]    = '{kind: KIND_ERASE, out_address: erase_addr, word_data: '0};
      slot_v[2]      = 1'b0;
      slot_v[3]      = 1'b1;
      slot_v[4]      = 1'b0;
      word_buf_nxt   = wb_flushed;
      next_addr_nxt  = next_addr_r;
      word_pend_nxt  = pend_flushed;
      chunk_open_nxt = chunk_flushed;
      run_open_nxt   = flush ? 1'b0 : run_open_r;
    end else begin
      slot_res[3]    = '{kind: KIND_WORD,
                         out_address: PORT_ADDR_W'({here[ADDR_BITS-1:2], 2'b00}),
                         word_data: wb_filled};
      slot_v[2]      = !chunk_flushed;
      slot_v[3]      = emit_word;
      slot_v[4]      = emit_commit;
      word_buf_nxt   = emit_word ? {WORD_W{1'b1}} : wb_filled;
      next_addr_nxt  = here_inc;
      word_pend_nxt  = !emit_word;
      chunk_open_nxt = !emit_commit;
      run_open_nxt   = !a_last_r;
    end
  end

  // Pick the lowest pending slot at or after slot_r.
  logic [NUM_SLOTS-1:0] pend_v;
  logic [SLOT_W-1:0]    pick;
  logic                 pick_found;
  logic                 pick_last;
  logic                 out_free;
  logic                 load;
  logic                 retire;

  always_comb begin
    pick       = '0;
    pick_found = 1'b0;
    pick_last  = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pend_v[i] = slot_v[i] && (SLOT_W'(i) >= slot_r);
    end
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_v[i]) begin
        pick       = SLOT_W'(i);
        pick_last  = !pick_found;
        pick_found = 1'b1;
      end
    end
    // pick_last must reflect whether any slot above the lowest is pending.
    pick_last = (pend_v & ~(NUM_SLOTS'(1) << pick)) == '0;

    out_free  = !out_valid_r || out_tready;
    load      = a_valid_r && pick_found && out_free;
    retire    = a_valid_r && (!pick_found || (out_free && pick_last));
    in_tready = !a_valid_r || retire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      slot_r       <= '0;
      out_valid_r  <= 1'b0;
      word_buf_r   <= {WORD_W{1'b1}};
      next_addr_r  <= '0;
      word_pend_r  <= 1'b0;
      chunk_open_r <= 1'b0;
      run_open_r   <= 1'b0;
    end else begin
      if (in_tready) begin
        a_valid_r <= in_tvalid;
      end
      if (retire) begin
        slot_r       <= '0;
        word_buf_r   <= word_buf_nxt;
        next_addr_r  <= next_addr_nxt;
        word_pend_r  <= word_pend_nxt;
        chunk_open_r <= chunk_open_nxt;
        run_open_r   <= run_open_nxt;
      end else if (load) begin
        slot_r <= pick + SLOT_W'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_addr_r  <= in_tdata[PORT_ADDR_W-1:0];
      a_byte_r  <= in_tdata[PORT_ADDR_W +: BYTE_W];
      a_op_r    <= in_tuser[0];
      a_first_r <= in_tuser[1];
      a_last_r  <= in_tlast;
    end
    if (load) begin
      out_res_r  <= slot_res[pick];
      out_last_r <= pick_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.word_data, out_res_r.out_address};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;

endmodule
